### design/tbs_pkg.sv
// Shared types and constants for the two-stage tap burst sequencer.
package tbs_pkg;

  // Operation codes carried by an input transaction
  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_PULSES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_PULSES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LEN     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_LEN     = 2'd3;

  // Register reset values
  localparam logic [15:0] PULSE_LEN_RESET = 16'd10;
  localparam logic [15:0] PAUSE_LEN_RESET = 16'd1000;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic first_drive;
    logic second_drive;
    logic sequence_done;
    logic busy_res;
    logic in_first_stage;
  } result_t;

  typedef struct packed {
    logic [7:0]  first_stage_pulses;
    logic [7:0]  second_stage_pulses;
    logic [15:0] pulse_length_ms;
    logic [15:0] pause_length_ms;
  } cfg_t;

  typedef struct packed {
    logic        running;
    logic        stage_is_first;
    logic        pulse_high;
    logic [7:0]  pulse_count;
    logic [31:0] phase_begin_ms;
  } seq_state_t;

endpackage

### design/tbs_cfg_regs.sv
// Configuration register file for the burst sequencer.
module tbs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tbs_pkg::cfg_t                   cfg
);
  import tbs_pkg::*;

  // Register writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_stage_pulses  <= 8'd0;
      cfg.second_stage_pulses <= 8'd0;
      cfg.pulse_length_ms     <= PULSE_LEN_RESET;
      cfg.pause_length_ms     <= PAUSE_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_PULSES:  cfg.first_stage_pulses  <= cfg_data[7:0];
        CFG_SECOND_PULSES: cfg.second_stage_pulses <= cfg_data[7:0];
        CFG_PULSE_LEN:     cfg.pulse_length_ms     <= cfg_data;
        CFG_PAUSE_LEN:     cfg.pause_length_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/tbs_step.sv
// Next-state and result logic for one transaction of the burst sequencer.
module tbs_step (
  input  tbs_pkg::cfg_t       cfg,
  input  tbs_pkg::seq_state_t state,
  input  tbs_pkg::item_t      item,
  output tbs_pkg::seq_state_t state_next,
  output tbs_pkg::result_t    result
);
  import tbs_pkg::*;

  logic [31:0] elapsed;
  logic [31:0] phase_limit;
  logic        phase_over;
  logic [7:0]  count_inc;
  logic [7:0]  target;
  logic        any_pulses;
  logic        done;
  logic        high;

  // Wrapping elapsed time against the current phase length
  assign elapsed     = item.now_ms - state.phase_begin_ms;
  assign phase_limit = state.pulse_high ? {16'd0, cfg.pulse_length_ms}
                                        : {16'd0, cfg.pause_length_ms};
  assign phase_over  = (elapsed >= phase_limit);

  // Saturating pulse counter and stage target
  assign count_inc  = (state.pulse_count != COUNT_MAX) ? state.pulse_count + 8'd1
                                                       : state.pulse_count;
  assign target     = state.stage_is_first ? cfg.first_stage_pulses
                                           : cfg.second_stage_pulses;
  assign any_pulses = (cfg.first_stage_pulses != 8'd0) || (cfg.second_stage_pulses != 8'd0);

  // Operation decode and sequence update
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (item.operation)
      OP_ADVANCE: begin
        if (state.running && phase_over) begin
          state_next.phase_begin_ms = item.now_ms;
          if (!state.pulse_high) begin
            state_next.pulse_high = 1'b1;
          end else begin
            state_next.pulse_high  = 1'b0;
            state_next.pulse_count = count_inc;
            if (count_inc >= target) begin
              if (state.stage_is_first && (cfg.second_stage_pulses != 8'd0)) begin
                state_next.stage_is_first = 1'b0;
                state_next.pulse_count    = 8'd0;
              end else begin
                state_next.running        = 1'b0;
                state_next.stage_is_first = 1'b1;
                done                      = 1'b1;
              end
            end
          end
        end
      end
      OP_START: begin
        state_next.running        = any_pulses;
        state_next.stage_is_first = (cfg.first_stage_pulses != 8'd0) || !any_pulses;
        state_next.pulse_high     = 1'b0;
        state_next.pulse_count    = 8'd0;
        state_next.phase_begin_ms = item.now_ms;
      end
      OP_STOP: begin
        state_next.running    = 1'b0;
        state_next.pulse_high = 1'b0;
      end
      default: ;
    endcase
  end

  // Result fields follow the updated state
  assign high                  = state_next.running && state_next.pulse_high;
  assign result.first_drive    = high && state_next.stage_is_first;
  assign result.second_drive   = high && !state_next.stage_is_first;
  assign result.sequence_done  = done;
  assign result.busy_res       = state_next.running;
  assign result.in_first_stage = state_next.running && state_next.stage_is_first;

endmodule

### design/tbs_seq_core.sv
// Input register, sequence state and result register of the burst sequencer.
module tbs_seq_core (
  input  logic              clk,
  input  logic              rst,
  input  tbs_pkg::cfg_t     cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  tbs_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output tbs_pkg::result_t  result
);
  import tbs_pkg::*;

  logic       in_valid;
  item_t      in_item;
  seq_state_t state;
  seq_state_t state_next;
  result_t    step_result;
  logic       res_load;
  logic       step_fire;

  // Pipeline handshake: result register frees the input register
  assign res_load   = !result_valid || result_ready;
  assign step_fire  = in_valid && res_load;
  assign item_ready = !in_valid || res_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_item <= item;
    end
  end

  tbs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (step_result)
  );

  // Sequence state advances as the transaction moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.running        <= 1'b0;
      state.stage_is_first <= 1'b1;
      state.pulse_high     <= 1'b0;
      state.pulse_count    <= 8'd0;
      state.phase_begin_ms <= 32'd0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result <= step_result;
    end
  end

  // Checks
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(state))
    else $error("sequence state changed without a transaction");

  a_pulse_needs_run: assert property (@(posedge clk) disable iff (rst)
    !state.running |-> !state.pulse_high)
    else $error("pulse high while sequence idle");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sequence_done |-> !result.busy_res && state.stage_is_first)
    else $error("done reported while sequence still running");

  a_one_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.first_drive && result.second_drive))
    else $error("both outputs driven at once");

  a_stage_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_first_stage |-> result.busy_res && !result.second_drive)
    else $error("first-stage flag inconsistent with busy or drives");

endmodule

### design/two_stage_tap_burst_sequencer.sv
// Top level of the two-stage tap burst sequencer.
//
//  Channel  Signals                             Direction  Content
//  item     item_valid/item_ready/item          in         operation, now_ms
//  result   result_valid/result_ready/result    out        drives, done, busy, stage
//  cfg      cfg_wr_en/cfg_index/cfg_data        in         register writes
//
// Each transaction is captured in the input register and then moves on to the
// result register once that register is free; one item is taken per cycle
// while the result side is not stalled.
// The single 32-bit elapsed-time subtract and compare sets the cycle time.
// Reset (rst, synchronous) clears both register stages and the sequence state.
// A stalled result holds the result register, and the input register behind it
// keeps taking a transaction while its own slot is free.
module two_stage_tap_burst_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  tbs_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tbs_pkg::result_t                result,
  input  logic                            cfg_wr_en,
  input  logic [tbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tbs_pkg::*;

  cfg_t cfg;

  tbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbs_seq_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### tb/two_stage_tap_burst_sequencer_tb.sv
// Self-checking testbench for the two-stage tap burst sequencer.
`timescale 1ns / 1ps

module two_stage_tap_burst_sequencer_tb;
  import tbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LATENCY = 2;
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 100;
  localparam int PRESSURE_PHASE = 5;

  // Result patterns, bit order: first, second, done, busy, in_first
  localparam result_t RES_IDLE        = 5'b00000;
  localparam result_t RES_BUSY_SECOND = 5'b00010;
  localparam result_t RES_BUSY_FIRST  = 5'b00011;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item_in;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result_out;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  two_stage_tap_burst_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Register mirror
  logic [7:0]  cfg_first;
  logic [7:0]  cfg_second;
  logic [15:0] cfg_pulse;
  logic [15:0] cfg_pause;

  // Sequence state mirror
  logic        seq_running;
  logic        seq_stage_first;
  logic        seq_pulse_high;
  logic [7:0]  seq_count;
  logic [31:0] seq_phase_start;

  result_t pending_results[$];
  result_t want_result;
  string   field_names [0:4] = '{"in_first_stage", "busy_res", "sequence_done",
                                 "second_drive", "first_drive"};

  int  fail_count = 0;
  int  items_sent = 0;
  int  dones_seen = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  // Directed stimulus rows: either a register write or a transaction
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [15:0]            reg_val;
    item_t                  it;
    bit                     typed;
    result_t                want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void dir_item(logic [1:0] op, logic [31:0] now, bit typed,
                                   result_t want);
    dir_row_t r;
    r = '{default: '0};
    r.it.operation = op;
    r.it.now_ms = now;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_cfg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  // Burst predictor: updates the state mirror and returns the result
  function automatic result_t burst_predict(item_t it);
    logic [31:0] elapsed;
    logic [7:0]  goal;
    logic        done;
    logic        high;
    result_t     r;
    done = 1'b0;
    case (it.operation)
      OP_ADVANCE: begin
        if (seq_running) begin
          elapsed = it.now_ms - seq_phase_start;
          if (!seq_pulse_high) begin
            if (elapsed >= {16'd0, cfg_pause}) begin
              seq_pulse_high = 1'b1;
              seq_phase_start = it.now_ms;
            end
          end else if (elapsed >= {16'd0, cfg_pulse}) begin
            seq_pulse_high = 1'b0;
            seq_phase_start = it.now_ms;
            if (seq_count != COUNT_MAX) seq_count = seq_count + 8'd1;
            goal = seq_stage_first ? cfg_first : cfg_second;
            if (seq_count >= goal) begin
              // first stage hands over to the second, else the burst ends
              if (seq_stage_first && cfg_second != 8'd0) begin
                seq_stage_first = 1'b0;
                seq_count = 8'd0;
              end else begin
                seq_running = 1'b0;
                seq_stage_first = 1'b1;
                done = 1'b1;
              end
            end
          end
        end
      end
      OP_START: begin
        seq_running = (cfg_first != 8'd0) || (cfg_second != 8'd0);
        seq_stage_first = (cfg_first != 8'd0) || !seq_running;
        seq_pulse_high = 1'b0;
        seq_count = 8'd0;
        seq_phase_start = it.now_ms;
      end
      OP_STOP: begin
        seq_running = 1'b0;
        seq_pulse_high = 1'b0;
      end
      default: ;
    endcase
    high = seq_running && seq_pulse_high;
    r.first_drive = high && seq_stage_first;
    r.second_drive = high && !seq_stage_first;
    r.sequence_done = done;
    r.busy_res = seq_running;
    r.in_first_stage = seq_running && seq_stage_first;
    return r;
  endfunction

  // Called at a falling edge while the block is idle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FIRST_PULSES:  cfg_first = val[7:0];
      CFG_SECOND_PULSES: cfg_second = val[7:0];
      CFG_PULSE_LEN:     cfg_pulse = val;
      CFG_PAUSE_LEN:     cfg_pause = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_quiet();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Offer one transaction; valid stays high afterwards unless a gap follows
  task automatic offer_item(item_t it, bit typed, result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    item_in <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = burst_predict(it);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %b", result_out);
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        for (int b = 0; b < 5; b++) begin
          if (result_out[b] !== want_result[b]) begin
            $error("%s: expected %0d, got %0d", field_names[b], want_result[b],
                   result_out[b]);
            fail_count++;
          end
        end
        if (result_out.sequence_done) dones_seen++;
      end
    end
  end

  // Stimulus
  initial begin
    int          ph;
    int          n;
    int          roll;
    int          step_cap;
    item_t       it;
    logic [1:0]  op;
    logic [31:0] now;
    logic [7:0]  f;
    logic [7:0]  s;
    logic [15:0] pl;
    logic [15:0] pa;

    rst = 1'b1;
    item_valid = 1'b0;
    item_in = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_first = 8'd0;
    cfg_second = 8'd0;
    cfg_pulse = PULSE_LEN_RESET;
    cfg_pause = PAUSE_LEN_RESET;
    seq_running = 1'b0;
    seq_stage_first = 1'b1;
    seq_pulse_high = 1'b0;
    seq_count = 8'd0;
    seq_phase_start = 32'd0;
    now = 32'd0;

    // Reset register defaults: idle behavior and both counts zero
    dir_item(OP_ADVANCE, 32'd0, 1'b1, RES_IDLE);
    dir_item(OP_START, 32'hFFFF_FFFF, 1'b1, RES_IDLE);
    dir_item(OP_STOP, 32'd0, 1'b1, RES_IDLE);
    dir_item(OP_UNUSED, 32'h5A5A_A5A5, 1'b1, RES_IDLE);
    // No first-stage pulses, zero lengths: start lands in stage two
    dir_cfg(CFG_FIRST_PULSES, 16'd0);
    dir_cfg(CFG_SECOND_PULSES, 16'd2);
    dir_cfg(CFG_PULSE_LEN, 16'd0);
    dir_cfg(CFG_PAUSE_LEN, 16'd0);
    dir_item(OP_START, 32'd100, 1'b1, RES_BUSY_SECOND);
    repeat (4) dir_item(OP_ADVANCE, 32'd100, 1'b0, RES_IDLE);
    // Register maxima, time wrap, restart, unused code and stop
    dir_cfg(CFG_FIRST_PULSES, 16'd255);
    dir_cfg(CFG_SECOND_PULSES, 16'd255);
    dir_cfg(CFG_PULSE_LEN, 16'hFFFF);
    dir_cfg(CFG_PAUSE_LEN, 16'hFFFF);
    dir_item(OP_START, 32'hFFFF_FFF0, 1'b1, RES_BUSY_FIRST);
    dir_item(OP_ADVANCE, 32'h0000_FFEE, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'h0000_FFEF, 1'b0, RES_IDLE);
    dir_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, RES_IDLE);
    dir_item(OP_START, 32'h0000_FFEF, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'd0, 1'b0, RES_IDLE);
    dir_item(OP_STOP, 32'd1, 1'b1, RES_IDLE);
    dir_item(OP_ADVANCE, 32'hFFFF_FFFF, 1'b1, RES_IDLE);
    // Single pulse at default timing, edges of pause and pulse
    dir_cfg(CFG_FIRST_PULSES, 16'd1);
    dir_cfg(CFG_SECOND_PULSES, 16'd0);
    dir_cfg(CFG_PULSE_LEN, PULSE_LEN_RESET);
    dir_cfg(CFG_PAUSE_LEN, PAUSE_LEN_RESET);
    dir_item(OP_START, 32'd0, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'd999, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'd1000, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'd1009, 1'b0, RES_IDLE);
    dir_item(OP_ADVANCE, 32'd1010, 1'b0, RES_IDLE);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_quiet();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with a fresh register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();
      case (ph)
        1: begin
          f = 8'd0;
          s = 8'd0;
          pl = 16'($urandom_range(0, 12));
          pa = 16'($urandom_range(0, 12));
        end
        2: begin
          f = 8'd255;
          s = 8'd255;
          pl = 16'd0;
          pa = 16'd0;
        end
        3: begin
          f = 8'($urandom_range(1, 3));
          s = 8'($urandom_range(0, 3));
          pl = 16'hFFFF;
          pa = 16'hFFFF;
        end
        default: begin
          f = 8'($urandom_range(0, 4));
          s = 8'($urandom_range(0, 4));
          pl = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                               : $urandom_range(0, 12));
          pa = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                               : $urandom_range(0, 12));
        end
      endcase
      write_reg(CFG_FIRST_PULSES, {8'd0, f});
      write_reg(CFG_SECOND_PULSES, {8'd0, s});
      write_reg(CFG_PULSE_LEN, pl);
      write_reg(CFG_PAUSE_LEN, pa);

      // No idling in the pressure phase, some quiet phases, and the last one
      idle_on = (ph % 4 != 3) && (ph != RAND_PHASES - 1) && (ph != PRESSURE_PHASE);
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      if ($urandom_range(0, 2) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 400);
      step_cap = ((pl > pa) ? pl : pa) / 4 + 3;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0) now = $urandom();
        else now = now + $urandom_range(0, step_cap);
        // Mostly well-formed bursts: start when idle, then advance time
        if (!seq_running && roll < 60) op = OP_START;
        else if (roll < 3) op = OP_STOP;
        else if (roll < 5) op = OP_UNUSED;
        else if (roll < 8) op = OP_START;
        else op = OP_ADVANCE;
        it.operation = op;
        it.now_ms = now;
        offer_item(it, 1'b0, RES_IDLE);
      end
    end

    wait_quiet();
    repeat (LATENCY + 4) @(posedge clk);

    $display("Ran %0d transactions with %0d register writes across %0d settings",
             items_sent, reg_writes, RAND_PHASES + 3);
    $display("Saw %0d burst completions; %0d field mismatches", dones_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/tbs_pkg.sv
design/tbs_cfg_regs.sv
design/tbs_step.sv
design/tbs_seq_core.sv
design/two_stage_tap_burst_sequencer.sv
tb/two_stage_tap_burst_sequencer_tb.sv
